@@ hw/rtl/mwo_pkg.sv @@
// Shared types, widths and constants of the mecanum wheel odometry unit.
`default_nettype none

package mwo_pkg;

   // Field and register widths.
   localparam int TICK_W = 32;
   localparam int SEC_W  = 32;
   localparam int NSEC_W = 30;
   localparam int CSR_W  = 16;
   localparam int OUT_W  = 32;

   // Gear ratio between motor and wheel; the datapath widths allow up to 255.
   localparam int unsigned GEAR_RATIO = 5;

   // Internal widths, sized for the worst case of every input and register.
   localparam int SUM_W    = 35;   // signed sum of four count deltas
   localparam int MAG_W    = 34;   // magnitude of such a sum
   localparam int DS_W     = 33;   // signed seconds difference
   localparam int DSMAG_W  = 32;
   localparam int DN_W     = 31;   // signed nanoseconds difference
   localparam int DT_W     = 62;   // positive time delta in nanoseconds
   localparam int CPRGR_W  = 24;   // counts per revolution times gear ratio
   localparam int HW4_W    = 19;   // four times (half length + half width)
   localparam int BASE_W   = 86;   // dt * counts_per_rev * gear ratio
   localparam int DENV_SH  = 18;
   localparam int DEN_W    = 105;
   localparam int MW_W     = 50;   // |S| * wheel_radius
   localparam int NUM_W    = 98;   // |S| * wheel_radius * K
   localparam int ACC_W    = 105;
   localparam int X_W      = 16;   // multiplier chunk operand
   localparam int Y_W      = 50;   // multiplier full operand
   localparam int P_W      = X_W + Y_W;
   localparam int XSRC_W   = 96;
   localparam int CHUNK_W  = 3;
   localparam int Q_W      = 32;
   localparam int DIV_W    = DEN_W + Q_W;
   localparam int CNT_W    = 6;
   localparam int NUM_AXES = 3;

   // Sequencing lengths.
   localparam int SEC_CHUNKS  = 2;
   localparam int BASE_CHUNKS = 4;
   localparam int DENW_CHUNKS = 6;
   localparam int NUM_CHUNKS  = 4;
   localparam int DIV_STEPS   = Q_W + 1;

   // Nanoseconds per second, and round(2*pi * 1e9 * 2^16).
   localparam logic [31:0] NS_PER_SEC  = 32'd1000000000;
   localparam logic [48:0] TWOPI_E9_Q16 = 49'd411774832291321;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_COUNTS_PER_REV = 2'd0;
   localparam logic [1:0] CSR_HALF_LENGTH    = 2'd1;
   localparam logic [1:0] CSR_HALF_WIDTH     = 2'd2;
   localparam logic [1:0] CSR_WHEEL_RADIUS   = 2'd3;

   localparam logic [CSR_W-1:0] RST_COUNTS_PER_REV = 16'd42;
   localparam logic [CSR_W-1:0] RST_HALF_LENGTH    = 16'd5046;
   localparam logic [CSR_W-1:0] RST_HALF_WIDTH     = 16'd13107;
   localparam logic [CSR_W-1:0] RST_WHEEL_RADIUS   = 16'd11076;

   typedef struct packed {
      logic signed [TICK_W-1:0] ticks_front_left;
      logic signed [TICK_W-1:0] ticks_front_right;
      logic signed [TICK_W-1:0] ticks_rear_left;
      logic signed [TICK_W-1:0] ticks_rear_right;
      logic [SEC_W-1:0]         stamp_seconds;
      logic [NSEC_W-1:0]        stamp_nanoseconds;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] velocity_x;
      logic signed [OUT_W-1:0] velocity_y;
      logic signed [OUT_W-1:0] yaw_rate;
      logic                    time_error;
   } rsp_type;

   typedef struct packed {
      logic [CSR_W-1:0] counts_per_rev;
      logic [CSR_W-1:0] half_length;
      logic [CSR_W-1:0] half_width;
      logic [CSR_W-1:0] wheel_radius;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_SEC,
      MUL_BASE,
      MUL_DENW,
      MUL_MW,
      MUL_NUM
   } mul_sel_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic                load_in;
      logic                sums_load;
      logic                mul_en;
      logic                mul_clear;
      mul_sel_type         mul_sel;
      logic [CHUNK_W-1:0]  mul_chunk;
      logic                dt_load;
      logic                chk;
      logic                base_load;
      logic                denw_load;
      logic                mw_load;
      axis_type            axis;
      logic                div_start;
      logic                div_step;
      logic                div_first;
      logic                res_load;
      logic                out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic dt_pos;
   } dp_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/mwo_datapath.sv @@
// Datapath: stored samples, shared chunked multiplier, serial divider, result registers.
`default_nettype none

module mwo_datapath
   import mwo_pkg::*;
(
   input  wire logic       clock,
   input  wire req_type    req_data,
   input  wire cfg_type    cfg,
   input  wire dp_cmd_type cmd,
   output dp_sts_type      sts,
   output rsp_type         rsp_data
);

   // Previous sample.
   logic [TICK_W-1:0] prev_ticks_ff [4];
   logic [SEC_W-1:0]  prev_sec_ff;
   logic [NSEC_W-1:0] prev_nsec_ff;

   // Differences of the current sample.
   logic [TICK_W-1:0]  delta_ff [4];
   logic [DSMAG_W-1:0] ds_mag_ff;
   logic               ds_neg_ff;
   logic [DN_W-1:0]    dn_ff;

   logic [MAG_W-1:0] s_mag_ff [NUM_AXES];
   logic             s_neg_ff [NUM_AXES];

   logic [CPRGR_W-1:0] cpr_gr_ff;
   logic [HW4_W-1:0]   hw4_ff;

   logic [ACC_W-1:0]  acc_ff;
   logic [DT_W-1:0]   dt_mag_ff;
   logic              dt_pos_ff;
   logic [BASE_W-1:0] base_ff;
   logic [DEN_W-1:0]  den_w_ff;
   logic [MW_W-1:0]   mw_ff;

   logic [NUM_W-1:0] rem_ff;
   logic [DIV_W-1:0] dsh_ff;
   logic [Q_W-1:0]   q_ff;
   logic             ovf_ff;
   logic             nz_ff;

   logic [OUT_W-1:0] res_ff [NUM_AXES];
   logic             err_ff;
   rsp_type          out_ff;

   // Input differences.
   logic [TICK_W-1:0] delta_in [4];
   logic [DS_W-1:0]   ds_full;
   logic [DS_W-1:0]   ds_negated;
   logic [DN_W-1:0]   dn_in;

   always_comb begin
      delta_in[0] = req_data.ticks_front_left - prev_ticks_ff[0];
      delta_in[1] = req_data.ticks_front_right - prev_ticks_ff[1];
      delta_in[2] = req_data.ticks_rear_left - prev_ticks_ff[2];
      delta_in[3] = req_data.ticks_rear_right - prev_ticks_ff[3];
      ds_full     = {1'b0, req_data.stamp_seconds} - {1'b0, prev_sec_ff};
      ds_negated  = DS_W'(0) - ds_full;
      dn_in       = {1'b0, req_data.stamp_nanoseconds} - {1'b0, prev_nsec_ff};
   end

   // Wheel sums for the three body axes.
   logic signed [SUM_W-1:0] ext   [4];
   logic signed [SUM_W-1:0] s_sum [NUM_AXES];
   logic [SUM_W-1:0]        s_neg_val [NUM_AXES];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ext[i] = {{(SUM_W-TICK_W){delta_ff[i][TICK_W-1]}}, delta_ff[i]};
      end
      s_sum[AXIS_X] = ext[0] + ext[1] + ext[2] + ext[3];
      s_sum[AXIS_Y] = ext[1] + ext[2] - ext[0] - ext[3];
      s_sum[AXIS_Z] = ext[1] + ext[3] - ext[0] - ext[2];
      for (int i = 0; i < NUM_AXES; i++) begin
         s_neg_val[i] = SUM_W'(0) - s_sum[i];
      end
   end

   // Shared multiplier: a 16-bit chunk times a full operand, shifted into the accumulator.
   logic [XSRC_W-1:0] x_src;
   logic [X_W-1:0]    x_op;
   logic [Y_W-1:0]    y_op;
   logic [P_W-1:0]    product;
   logic [ACC_W-1:0]  acc_base;
   logic [ACC_W-1:0]  acc_in;

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_SEC: begin
            x_src = XSRC_W'(NS_PER_SEC);
            y_op  = Y_W'(ds_mag_ff);
         end
         MUL_BASE: begin
            x_src = XSRC_W'(dt_mag_ff);
            y_op  = Y_W'(cpr_gr_ff);
         end
         MUL_DENW: begin
            x_src = XSRC_W'(base_ff);
            y_op  = Y_W'(hw4_ff);
         end
         MUL_MW: begin
            x_src = XSRC_W'(cfg.wheel_radius);
            y_op  = Y_W'(s_mag_ff[cmd.axis]);
         end
         MUL_NUM: begin
            x_src = XSRC_W'(TWOPI_E9_Q16);
            y_op  = mw_ff;
         end
         default: begin
            x_src = '0;
            y_op  = '0;
         end
      endcase
      x_op     = x_src[{cmd.mul_chunk, 4'b0000} +: X_W];
      product  = P_W'(x_op) * P_W'(y_op);
      acc_base = cmd.mul_clear ? '0 : acc_ff;
      acc_in   = acc_base + (ACC_W'(product) << {cmd.mul_chunk, 4'b0000});
   end

   // Signed time delta from |ds| * 1e9 held in the accumulator.
   logic [63:0] sec_prod;
   logic [63:0] dt_full;

   always_comb begin
      sec_prod = {2'b00, acc_ff[DT_W-1:0]};
      dt_full  = (ds_neg_ff ? 64'd0 - sec_prod : sec_prod)
                 + {{(64-DN_W){dn_ff[DN_W-1]}}, dn_ff};
   end

   // Divider: the first step only detects a quotient of 2^32 or more.
   logic [DEN_W-1:0] den_sel;
   logic [DIV_W-1:0] rem_ext;
   logic             div_ge;

   always_comb begin
      den_sel = (cmd.axis == AXIS_Z) ? den_w_ff : {1'b0, base_ff, {DENV_SH{1'b0}}};
      rem_ext = DIV_W'(rem_ff);
      div_ge  = rem_ext >= dsh_ff;
   end

   // Saturation and sign of the finished quotient.
   logic             r_neg;
   logic [Q_W-1:0]   limit;
   logic [Q_W-1:0]   q_sat;
   logic [OUT_W-1:0] res_val;

   always_comb begin
      r_neg   = s_neg_ff[cmd.axis];
      limit   = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      q_sat   = (ovf_ff || (q_ff > limit)) ? limit : q_ff;
      res_val = nz_ff ? (r_neg ? 32'd0 - q_sat : q_sat) : '0;
   end

   always_ff @(posedge clock) begin
      cpr_gr_ff <= CPRGR_W'(cfg.counts_per_rev) * CPRGR_W'(GEAR_RATIO);
      hw4_ff    <= {17'(cfg.half_length) + 17'(cfg.half_width), 2'b00};

      if (cmd.load_in) begin
         for (int i = 0; i < 4; i++) begin
            delta_ff[i] <= delta_in[i];
         end
         prev_ticks_ff[0] <= req_data.ticks_front_left;
         prev_ticks_ff[1] <= req_data.ticks_front_right;
         prev_ticks_ff[2] <= req_data.ticks_rear_left;
         prev_ticks_ff[3] <= req_data.ticks_rear_right;
         prev_sec_ff      <= req_data.stamp_seconds;
         prev_nsec_ff     <= req_data.stamp_nanoseconds;
         ds_neg_ff        <= ds_full[DS_W-1];
         ds_mag_ff        <= ds_full[DS_W-1] ? ds_negated[DSMAG_W-1:0]
                                             : ds_full[DSMAG_W-1:0];
         dn_ff            <= dn_in;
      end

      if (cmd.sums_load) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            s_neg_ff[i] <= s_sum[i][SUM_W-1];
            s_mag_ff[i] <= s_sum[i][SUM_W-1] ? s_neg_val[i][MAG_W-1:0]
                                             : s_sum[i][MAG_W-1:0];
         end
      end

      if (cmd.mul_en) begin
         acc_ff <= acc_in;
      end

      if (cmd.dt_load) begin
         dt_mag_ff <= dt_full[DT_W-1:0];
         dt_pos_ff <= !dt_full[63] && (dt_full != 64'd0);
      end

      if (cmd.base_load) begin
         base_ff <= acc_ff[BASE_W-1:0];
      end
      if (cmd.denw_load) begin
         den_w_ff <= acc_ff[DEN_W-1:0];
      end
      if (cmd.mw_load) begin
         mw_ff <= product[MW_W-1:0];
      end

      if (cmd.div_start) begin
         rem_ff <= acc_ff[NUM_W-1:0];
         nz_ff  <= |acc_ff;
         dsh_ff <= {den_sel, {Q_W{1'b0}}};
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.div_step) begin
         dsh_ff <= dsh_ff >> 1;
         if (cmd.div_first) begin
            ovf_ff <= div_ge && nz_ff;
         end else begin
            q_ff <= {q_ff[Q_W-2:0], div_ge};
            if (div_ge) begin
               rem_ff <= rem_ff - dsh_ff[NUM_W-1:0];
            end
         end
      end

      if (cmd.chk) begin
         err_ff <= !dt_pos_ff;
         if (!dt_pos_ff) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               res_ff[i] <= '0;
            end
         end
      end else if (cmd.res_load) begin
         res_ff[cmd.axis] <= res_val;
      end

      if (cmd.out_load) begin
         out_ff.velocity_x <= res_ff[AXIS_X];
         out_ff.velocity_y <= res_ff[AXIS_Y];
         out_ff.yaw_rate   <= res_ff[AXIS_Z];
         out_ff.time_error <= err_ff;
      end
   end

   assign sts.dt_pos = dt_pos_ff;
   assign rsp_data   = out_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mwo_ctrl.sv @@
// Controller: sequences the multiplier chunks, divider steps and result handshake.
`default_nettype none

module mwo_ctrl
   import mwo_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEC,
      ST_DT,
      ST_CHK,
      ST_BASE,
      ST_BASE_LD,
      ST_DENW,
      ST_DENW_LD,
      ST_MW,
      ST_NUM,
      ST_DIV_LD,
      ST_DIV,
      ST_RES,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   axis_type         axis_ff, axis_in;
   logic             have_prev_ff, have_prev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = MUL_SEC;
      cmd.axis      = axis_ff;
      cmd.mul_chunk = cnt_ff[CHUNK_W-1:0];
      state_in      = state_ff;
      cnt_in        = cnt_ff + CNT_W'(1);
      axis_in       = axis_ff;
      have_prev_in  = have_prev_ff | req_accept;

      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_in = req_accept;
            cnt_in      = '0;
            // The first request after reset only primes the stored sample.
            if (req_accept && have_prev_ff) begin
               state_in = ST_SEC;
            end
         end
         ST_SEC: begin
            cmd.sums_load = (cnt_ff == '0);
            cmd.mul_en    = 1'b1;
            cmd.mul_clear = (cnt_ff == '0);
            cmd.mul_sel   = MUL_SEC;
            if (cnt_ff == CNT_W'(SEC_CHUNKS - 1)) begin
               state_in = ST_DT;
            end
         end
         ST_DT: begin
            cmd.dt_load = 1'b1;
            state_in    = ST_CHK;
         end
         ST_CHK: begin
            cmd.chk = 1'b1;
            cnt_in  = '0;
            state_in = sts.dt_pos ? ST_BASE : ST_DONE;
         end
         ST_BASE: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_clear = (cnt_ff == '0);
            cmd.mul_sel   = MUL_BASE;
            if (cnt_ff == CNT_W'(BASE_CHUNKS - 1)) begin
               state_in = ST_BASE_LD;
            end
         end
         ST_BASE_LD: begin
            cmd.base_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DENW;
         end
         ST_DENW: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_clear = (cnt_ff == '0);
            cmd.mul_sel   = MUL_DENW;
            if (cnt_ff == CNT_W'(DENW_CHUNKS - 1)) begin
               state_in = ST_DENW_LD;
            end
         end
         ST_DENW_LD: begin
            cmd.denw_load = 1'b1;
            axis_in       = AXIS_X;
            state_in      = ST_MW;
         end
         ST_MW: begin
            // The wheel radius fits entirely in the lowest chunk.
            cmd.mul_sel   = MUL_MW;
            cmd.mul_chunk = '0;
            cmd.mw_load   = 1'b1;
            cnt_in        = '0;
            state_in      = ST_NUM;
         end
         ST_NUM: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_clear = (cnt_ff == '0);
            cmd.mul_sel   = MUL_NUM;
            if (cnt_ff == CNT_W'(NUM_CHUNKS - 1)) begin
               state_in = ST_DIV_LD;
            end
         end
         ST_DIV_LD: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            cmd.res_load = 1'b1;
            unique case (axis_ff)
               AXIS_X: begin
                  axis_in  = AXIS_Y;
                  state_in = ST_MW;
               end
               AXIS_Y: begin
                  axis_in  = AXIS_Z;
                  state_in = ST_MW;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            // Wait until the output register is free before handing over.
            cmd.out_load = !rsp_valid_ff || !rsp_stall;
            if (cmd.out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= AXIS_X;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/mecanum_wheel_odometry_unit.sv @@
// Top level of the mecanum wheel odometry unit: configuration registers, controller, datapath.
// A request is taken only while the unit is idle; the first request after reset gives no response.
// Later requests give a response; when time did not advance it skips the multiplier and divider.
// The processing time is set by the shared 16x50 multiplier and the
// bit-serial divider, which runs three 33-step divisions in turn.
// Synchronous reset restores the register defaults and forgets the stored sample.
`default_nettype none

module mecanum_wheel_odometry_unit
   import mwo_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   cfg_type    cfg_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counts_per_rev <= RST_COUNTS_PER_REV;
         cfg_ff.half_length    <= RST_HALF_LENGTH;
         cfg_ff.half_width     <= RST_HALF_WIDTH;
         cfg_ff.wheel_radius   <= RST_WHEEL_RADIUS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COUNTS_PER_REV: cfg_ff.counts_per_rev <= csr_wr_data;
            CSR_HALF_LENGTH:    cfg_ff.half_length    <= csr_wr_data;
            CSR_HALF_WIDTH:     cfg_ff.half_width     <= csr_wr_data;
            CSR_WHEEL_RADIUS:   cfg_ff.wheel_radius   <= csr_wr_data;
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   mwo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mwo_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
